// ===== src/msm_pkg.sv =====
`default_nettype none

package msm_pkg;

    // Field and register widths
    localparam int OPCODE_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int PWM_W     = 10;
    localparam int RPM_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;
    localparam int WIN_W     = 4;
    localparam int PPR_W     = 8;
    localparam int SCALE_W   = 10;
    localparam int ALPHA_W   = 9;
    localparam int GAIN_W    = 10;

    // Datapath widths
    localparam int MUL_A_W   = 10;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int NUM_W     = PPR_W + SCALE_W;
    localparam int QUO_W     = NUM_W + 8;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int GAIN_SHIFT = 16;

    // Constants
    localparam int MSM_TABLE_ENTRIES = 101;
    localparam int TABLE_TOP         = 356;
    localparam logic [BYTE_W-1:0]  START_BYTE = 8'hFF;
    localparam logic [RPM_W-1:0]   Q24_MAX    = 24'hFF_FFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;

    // Register reset values
    localparam logic [WIN_W-1:0]   WINDOW_TICKS_RST   = 4'd4;
    localparam logic [PPR_W-1:0]   PULSES_PER_REV_RST = 8'd8;
    localparam logic [SCALE_W-1:0] RPM_SCALE_RST      = 10'd240;
    localparam logic [ALPHA_W-1:0] ALPHA_RST          = 9'd205;
    localparam logic [GAIN_W-1:0]  GAIN_RST           = 10'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_TICKS   = 3'd0,
        CFG_PULSES_PER_REV = 3'd1,
        CFG_RPM_SCALE      = 3'd2,
        CFG_ALPHA          = 3'd3,
        CFG_GAIN           = 3'd4
    } t_cfg_idx;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PULSE = 2'd0,
        OP_TICK  = 2'd1,
        OP_BYTE  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MUL_NUM  = 2'd0,
        MUL_NEW  = 2'd1,
        MUL_OLD  = 2'd2,
        MUL_GAIN = 2'd3
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     latch;
        logic     decode;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_load;
        logic     div_step;
        logic     raw_take;
        logic     mix_load;
        logic     mix_add;
        logic     store;
        logic     load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic win_close;
        logic filt_nz;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/msm_dp.sv =====
`default_nettype none

module msm_dp #(
    parameter int TABLE_ENTRIES = msm_pkg::MSM_TABLE_ENTRIES
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [msm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [msm_pkg::CFG_W-1:0]             i_cfg_data,
    input  wire logic [msm_pkg::OPCODE_W-1:0]          i_opcode,
    input  wire logic [msm_pkg::BYTE_W-1:0]            i_rx_byte,
    input  wire msm_pkg::t_dp_cmd                      i_cmd,
    output msm_pkg::t_dp_stat                          o_stat,
    output logic [msm_pkg::PWM_W-1:0]                  o_pwm_compare,
    output logic [msm_pkg::RPM_W-1:0]                  o_rpm_q8,
    output logic                                       o_rpm_report,
    output logic                                       o_command_applied
);
    import msm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [BYTE_W-1:0] LAST_IDX = BYTE_W'(TABLE_ENTRIES - 1);

    // Configuration registers
    logic [WIN_W-1:0]   r_window_ticks;
    logic [PPR_W-1:0]   r_pulses_per_rev;
    logic [SCALE_W-1:0] r_rpm_scale;
    logic [ALPHA_W-1:0] r_alpha;
    logic [GAIN_W-1:0]  r_gain;

    // Event state
    logic [OPCODE_W-1:0] r_opcode;
    logic [BYTE_W-1:0]   r_byte;
    logic [WIN_W-1:0]    r_tick;
    logic [PPR_W-1:0]    r_pulse;
    logic [RPM_W-1:0]    r_filt;
    logic [1:0]          r_pos;
    logic                r_started;
    logic [BYTE_W-1:0]   r_duty_byte;
    logic [BYTE_W-1:0]   r_duty;
    logic [BYTE_W-1:0]   r_motor;
    logic                r_report;
    logic                r_applied;

    // Arithmetic registers
    logic [PROD_W-1:0]  r_prod;
    logic [MUL_B_W-1:0] r_acc;
    logic [QUO_W-1:0]   r_quo;
    logic [PPR_W-1:0]   r_rem;
    logic [RPM_W-1:0]   r_raw;

    logic [WIN_W-1:0]   w_tick_inc;
    logic               w_close;
    logic [ALPHA_W-1:0] w_alpha;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PPR_W:0]     w_shift;
    logic               w_ge;
    logic [PPR_W:0]     w_diff;
    logic [RPM_W-1:0]   w_raw_sat;
    logic [RPM_W-1:0]   w_gain_sat;
    logic [1:0]         w_pos;
    logic [IDX_W-1:0]   w_idx;
    logic [PWM_W-1:0]   w_table [TABLE_ENTRIES];

    // Duty table: entry i is i * 356 / (entries - 1)
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_table
        localparam int ENTRY = (g * TABLE_TOP) / (TABLE_ENTRIES - 1);
        assign w_table[g] = PWM_W'(ENTRY);
    end

    // Window tick compare
    assign w_tick_inc = r_tick + WIN_W'(1);
    assign w_close    = (t_opcode'(r_opcode) == OP_TICK) && (w_tick_inc >= r_window_ticks);

    assign o_stat.win_close = w_close;
    assign o_stat.filt_nz   = (r_filt != '0);

    // Filter weight, limited to one
    assign w_alpha = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // Shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_NUM: begin
                w_mul_a = r_rpm_scale;
                w_mul_b = MUL_B_W'(r_pulse);
            end
            MUL_NEW: begin
                w_mul_a = MUL_A_W'(w_alpha);
                w_mul_b = MUL_B_W'(r_raw);
            end
            MUL_OLD: begin
                w_mul_a = MUL_A_W'(ALPHA_ONE - w_alpha);
                w_mul_b = MUL_B_W'(r_filt);
            end
            MUL_GAIN: begin
                w_mul_a = r_gain;
                w_mul_b = r_acc;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Restoring divider step
    assign w_shift = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_pulses_per_rev});
    assign w_diff  = w_shift - {1'b0, r_pulses_per_rev};

    // Saturate quotient and gained filter output to 24 bits
    assign w_raw_sat  = (r_quo[QUO_W-1:RPM_W] != '0) ? Q24_MAX : r_quo[RPM_W-1:0];
    assign w_gain_sat = (r_prod[PROD_W-1:GAIN_SHIFT+RPM_W] != '0) ? Q24_MAX :
                        r_prod[GAIN_SHIFT+RPM_W-1:GAIN_SHIFT];

    // A start byte always restarts the frame
    assign w_pos = (r_byte == START_BYTE) ? 2'd0 : r_pos;

    // Clamp duty into the table
    assign w_idx = (r_duty > LAST_IDX) ? IDX_W'(LAST_IDX) : IDX_W'(r_duty);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks   <= WINDOW_TICKS_RST;
            r_pulses_per_rev <= PULSES_PER_REV_RST;
            r_rpm_scale      <= RPM_SCALE_RST;
            r_alpha          <= ALPHA_RST;
            r_gain           <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_TICKS:   r_window_ticks   <= i_cfg_data[WIN_W-1:0];
                CFG_PULSES_PER_REV: r_pulses_per_rev <= i_cfg_data[PPR_W-1:0];
                CFG_RPM_SCALE:      r_rpm_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_ALPHA:          r_alpha          <= i_cfg_data[ALPHA_W-1:0];
                CFG_GAIN:           r_gain           <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_opcode <= i_opcode;
            r_byte   <= i_rx_byte;
        end
    end

    // Event state: counters, filter value, frame decoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_pulse     <= '0;
            r_filt      <= '0;
            r_pos       <= '0;
            r_started   <= 1'b0;
            r_duty_byte <= '0;
            r_duty      <= '0;
            r_motor     <= '0;
            r_report    <= 1'b0;
            r_applied   <= 1'b0;
        end else begin
            if (i_cmd.decode) begin
                r_report  <= 1'b0;
                r_applied <= 1'b0;
                unique case (t_opcode'(r_opcode))
                    OP_PULSE: begin
                        if (r_pulse != '1) begin
                            r_pulse <= r_pulse + PPR_W'(1);
                        end
                    end
                    OP_TICK: begin
                        if (w_close) begin
                            r_tick   <= '0;
                            r_report <= (r_motor == BYTE_W'(1));
                        end else begin
                            r_tick <= w_tick_inc;
                        end
                    end
                    OP_BYTE: begin
                        case (w_pos)
                            2'd0: begin
                                r_started <= (r_byte == START_BYTE);
                                r_pos     <= 2'd1;
                            end
                            2'd1: begin
                                r_duty_byte <= r_byte;
                                r_pos       <= 2'd2;
                            end
                            default: begin
                                if (r_started) begin
                                    r_duty    <= r_duty_byte;
                                    r_motor   <= r_byte;
                                    r_applied <= 1'b1;
                                end
                                r_pos <= 2'd0;
                            end
                        endcase
                    end
                    OP_NONE: ;
                    default: ;
                endcase
            end
            // Take the raw speed when the filter is empty; drop the pulse count
            if (i_cmd.raw_take) begin
                r_pulse <= '0;
                if (r_filt == '0) begin
                    r_filt <= w_raw_sat;
                end
            end
            if (i_cmd.store) begin
                r_filt <= w_gain_sat;
            end
        end
    end

    // Multiplier, divider and mix accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        if (i_cmd.div_load) begin
            r_quo <= {r_prod[NUM_W-1:0], 8'd0};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PPR_W-1:0] : w_shift[PPR_W-1:0];
        end
        if (i_cmd.raw_take) begin
            r_raw <= w_raw_sat;
        end
        if (i_cmd.mix_load) begin
            r_acc <= r_prod[MUL_B_W-1:0];
        end else if (i_cmd.mix_add) begin
            r_acc <= r_acc + r_prod[MUL_B_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_pwm_compare     <= (r_motor != '0) ? w_table[w_idx] : '0;
            o_rpm_q8          <= r_filt;
            o_rpm_report      <= r_report;
            o_command_applied <= r_applied;
        end
    end

endmodule

`default_nettype wire

// ===== src/msm_ctrl.sv =====
`default_nettype none

module msm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire msm_pkg::t_dp_stat i_stat,
    output msm_pkg::t_dp_cmd       o_cmd
);
    import msm_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_NUM    = 12'b0000_0000_0100,
        S_DIVLD  = 12'b0000_0000_1000,
        S_DIV    = 12'b0000_0001_0000,
        S_RAW    = 12'b0000_0010_0000,
        S_MIXA   = 12'b0000_0100_0000,
        S_MIXB   = 12'b0000_1000_0000,
        S_MIXC   = 12'b0001_0000_0000,
        S_GAIN   = 12'b0010_0000_0000,
        S_STORE  = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } t_state;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Sequence one word through decode and, on window close, the speed math
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_NUM;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_stat.win_close ? S_NUM : S_FINISH;
            end
            S_NUM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NUM;
                n_state       = S_DIVLD;
            end
            S_DIVLD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_RAW;
                end else begin
                    n_cnt = r_cnt + DIV_CNT_W'(1);
                end
            end
            S_RAW: begin
                o_cmd.raw_take = 1'b1;
                n_state        = i_stat.filt_nz ? S_MIXA : S_FINISH;
            end
            S_MIXA: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_NEW;
                n_state       = S_MIXB;
            end
            S_MIXB: begin
                o_cmd.mix_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_OLD;
                n_state        = S_MIXC;
            end
            S_MIXC: begin
                o_cmd.mix_add = 1'b1;
                n_state       = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the result register is free
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== src/motor_speed_monitor_and_command.sv =====
`default_nettype none

// Motor speed monitor and command block. Each input word is one event:
// an encoder pulse, a window timer tick or a received serial byte, and each
// yields one result word with the PWM compare value, the filtered speed in
// Q8 rpm and two flags. Pulses, bytes and ticks that do not close a window
// go straight from decode to the result. A tick that closes a window runs
// the speed computation on one shared 10x33 multiplier and a one-bit-per-cycle
// divider over the 26-bit numerator, and skips the filter blend while the
// filter is empty. One word is in work at a time; the next word is taken
// while the previous result still waits in the output register.
module motor_speed_monitor_and_command #(
    parameter int TABLE_ENTRIES = msm_pkg::MSM_TABLE_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [msm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [msm_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [msm_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic [msm_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [msm_pkg::PWM_W-1:0]          o_pwm_compare,
    output logic [msm_pkg::RPM_W-1:0]          o_rpm_q8,
    output logic                               o_rpm_report,
    output logic                               o_command_applied
);
    import msm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    msm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    msm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_pwm_compare     (o_pwm_compare),
        .o_rpm_q8          (o_rpm_q8),
        .o_rpm_report      (o_rpm_report),
        .o_command_applied (o_command_applied)
    );

endmodule

`default_nettype wire

// ===== tb/motor_speed_monitor_and_command_test.sv =====
`timescale 1ns / 100ps

module motor_speed_monitor_and_command_test;
    import msm_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 500;
    localparam int RANDOM_PASSES = 10;
    localparam int TABLE_LAST   = MSM_TABLE_ENTRIES - 1;

    typedef struct packed {
        logic [PWM_W-1:0] pwm;
        logic [RPM_W-1:0] rpm;
        logic             report;
        logic             applied;
    } t_motor_status;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    t_cfg_idx             i_cfg_index = CFG_WINDOW_TICKS;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_opcode              i_opcode = OP_PULSE;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [PWM_W-1:0]     o_pwm_compare;
    logic [RPM_W-1:0]     o_rpm_q8;
    logic                 o_rpm_report;
    logic                 o_command_applied;

    // Predicted motor status words, oldest first
    t_motor_status status_due[$];

    // Register copies and block state as predicted
    logic [WIN_W-1:0]     win_ticks_m;
    logic [PPR_W-1:0]     ppr_m;
    logic [SCALE_W-1:0]   scale_m;
    logic [ALPHA_W-1:0]   alpha_m;
    logic [GAIN_W-1:0]    gain_m;
    logic [3:0]           tick_cnt;
    logic [7:0]           pulse_cnt;
    logic [RPM_W-1:0]     speed_filt;
    logic [1:0]           frame_pos;
    logic                 frame_ok;
    logic [7:0]           frame_duty;
    logic [7:0]           duty_sel;
    logic [7:0]           motor_mode;

    int                   fail_count = 0;
    int                   words_sent = 0;
    int                   burst_left = 0;
    int                   idle_cycles = 0;
    logic                 sender_gaps = 1'b1;
    logic                 ready_stalls = 1'b1;
    logic [15:0]          stall_pattern = 16'h5A5B;
    logic [5:0]           pattern_age = '0;

    motor_speed_monitor_and_command dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pwm_compare     (o_pwm_compare),
        .o_rpm_q8          (o_rpm_q8),
        .o_rpm_report      (o_rpm_report),
        .o_command_applied (o_command_applied)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Rotate a random stall pattern on the result side, reload it when the age counter reaches 63
    always @(negedge i_clk) begin : out_stall_gen
        logic [15:0] nxt;
        nxt = {stall_pattern[0], stall_pattern[15:1]};
        if (pattern_age == 6'd63) nxt = 16'($urandom) | 16'h0001;
        stall_pattern <= nxt;
        pattern_age   <= pattern_age + 6'd1;
        i_out_ready   <= ready_stalls ? stall_pattern[0] : 1'b1;
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : status_check
        t_motor_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_due.size() == 0) begin
                $error("result word with no prediction: pwm_compare=%0d rpm_q8=%0d",
                       o_pwm_compare, o_rpm_q8);
                fail_count++;
            end else begin
                want = status_due.pop_front();
                if (o_pwm_compare !== want.pwm) begin
                    $error("pwm_compare: expected %0d, got %0d", want.pwm, o_pwm_compare);
                    fail_count++;
                end
                if (o_rpm_q8 !== want.rpm) begin
                    $error("rpm_q8: expected %0d, got %0d", want.rpm, o_rpm_q8);
                    fail_count++;
                end
                if (o_rpm_report !== want.report) begin
                    $error("rpm_report: expected %0d, got %0d", want.report, o_rpm_report);
                    fail_count++;
                end
                if (o_command_applied !== want.applied) begin
                    $error("command_applied: expected %0d, got %0d",
                           want.applied, o_command_applied);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run when neither side has moved a word for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("motor_speed_monitor_and_command test failed");
            $finish;
        end
    end

    // Advance the predicted state by one event and queue the status it yields
    task automatic predict_status(t_opcode op, logic [BYTE_W-1:0] b);
        t_motor_status     s;
        longint unsigned   raw;
        longint unsigned   mix;
        longint unsigned   scaled;
        longint unsigned   a;
        int                duty_idx;
        s = '0;
        case (op)
            OP_PULSE: begin
                if (pulse_cnt != 8'd255) pulse_cnt = pulse_cnt + 8'd1;
            end
            OP_TICK: begin
                tick_cnt = tick_cnt + 4'd1;
                if (tick_cnt >= win_ticks_m) begin
                    tick_cnt = '0;
                    // Raw speed, a zero divisor saturates
                    if (ppr_m == 0) begin
                        raw = 64'(Q24_MAX);
                    end else begin
                        raw = (64'(pulse_cnt) * scale_m * 256) / ppr_m;
                        if (raw > Q24_MAX) raw = 64'(Q24_MAX);
                    end
                    // Filter only once the filtered speed is nonzero
                    if (speed_filt != 0) begin
                        a = (alpha_m > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_m);
                        mix = a * raw + (256 - a) * speed_filt;
                        scaled = (gain_m * mix) >> GAIN_SHIFT;
                        speed_filt = (scaled > Q24_MAX) ? Q24_MAX : scaled[RPM_W-1:0];
                    end else begin
                        speed_filt = raw[RPM_W-1:0];
                    end
                    pulse_cnt = '0;
                    s.report = (motor_mode == 8'd1);
                end
            end
            OP_BYTE: begin
                // A start byte always restarts the frame
                if (b == START_BYTE) frame_pos = 2'd0;
                case (frame_pos)
                    2'd0: begin
                        frame_ok  = (b == START_BYTE);
                        frame_pos = 2'd1;
                    end
                    2'd1: begin
                        frame_duty = b;
                        frame_pos  = 2'd2;
                    end
                    default: begin
                        if (frame_ok) begin
                            duty_sel   = frame_duty;
                            motor_mode = b;
                            s.applied  = 1'b1;
                        end
                        frame_pos = 2'd0;
                    end
                endcase
            end
            default: ;
        endcase
        duty_idx = (duty_sel > TABLE_LAST) ? TABLE_LAST : int'(duty_sel);
        s.pwm = (motor_mode != 0) ? PWM_W'(duty_idx * TABLE_TOP / TABLE_LAST) : '0;
        s.rpm = speed_filt;
        status_due.push_back(s);
    endtask

    // Send one event word, idling between bursts when gaps are enabled
    task automatic send_event(t_opcode op, logic [BYTE_W-1:0] b);
        int gap;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                @(negedge i_clk);
                i_in_valid = 1'b0;
                i_rx_byte  = BYTE_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_rx_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_status(op, b);
        if (op != OP_NONE) words_sent++;
    endtask

    // Hold the input side idle until every predicted word has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        case (idx)
            CFG_WINDOW_TICKS:   win_ticks_m = v[WIN_W-1:0];
            CFG_PULSES_PER_REV: ppr_m       = v[PPR_W-1:0];
            CFG_RPM_SCALE:      scale_m     = v[SCALE_W-1:0];
            CFG_ALPHA:          alpha_m     = v[ALPHA_W-1:0];
            CFG_GAIN:           gain_m      = v[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Write all five registers once the block is idle
    task automatic apply_settings(logic [CFG_W-1:0] w, logic [CFG_W-1:0] p,
                                  logic [CFG_W-1:0] sc, logic [CFG_W-1:0] al,
                                  logic [CFG_W-1:0] g);
        drain_results();
        write_reg(CFG_WINDOW_TICKS, w);
        write_reg(CFG_PULSES_PER_REV, p);
        write_reg(CFG_RPM_SCALE, sc);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_GAIN, g);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Favor zero, the range ends and the all-ones value of the field
    function automatic logic [CFG_W-1:0] pick_value(int lo, int hi, int top);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_W'(lo);
            2: return CFG_W'(hi);
            3: return CFG_W'(top);
            default: return CFG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // Mostly well-formed frames, pulse runs and tick runs; some noise and broken frames
    task automatic run_mix(int n);
        int               first;
        int               kind;
        int               len;
        logic [7:0]       duty;
        logic [7:0]       code;
        first = words_sent;
        while (words_sent - first < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                len = $urandom_range(1, 12);
                repeat (len) send_event(OP_PULSE, BYTE_W'($urandom));
            end else if (kind < 60) begin
                len = $urandom_range(1, win_ticks_m + 2);
                repeat (len) send_event(OP_TICK, BYTE_W'($urandom));
            end else if (kind < 85) begin
                case ($urandom_range(0, 3))
                    0, 1: duty = 8'($urandom_range(0, TABLE_LAST));
                    2: duty = 8'($urandom_range(TABLE_LAST + 1, 254));
                    default: duty = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0, 1: code = 8'd1;
                    2: code = 8'd0;
                    default: code = 8'($urandom);
                endcase
                send_event(OP_BYTE, START_BYTE);
                send_event(OP_BYTE, duty);
                send_event(OP_BYTE, code);
            end else if (kind < 92) begin
                // Frame without a start byte, or cut short
                len = $urandom_range(1, 3);
                if ($urandom_range(0, 1)) begin
                    send_event(OP_BYTE, BYTE_W'($urandom_range(0, 254)));
                end else begin
                    send_event(OP_BYTE, START_BYTE);
                end
                repeat (len) send_event(OP_BYTE, BYTE_W'($urandom));
            end else begin
                send_event(t_opcode'($urandom_range(0, 3)), BYTE_W'($urandom));
            end
        end
    endtask

    // Reset settings: unused opcode, clamped duty, first window, filter, frame restart
    task automatic test_reset_behavior();
        sender_gaps  = 1'b1;
        ready_stalls = 1'b1;
        send_event(OP_NONE, 8'hA5);
        send_event(OP_BYTE, START_BYTE);
        send_event(OP_BYTE, 8'd200);
        send_event(OP_BYTE, 8'd1);
        send_event(OP_PULSE, 8'h00);
        send_event(OP_PULSE, 8'hFF);
        send_event(OP_PULSE, 8'h5A);
        repeat (4) send_event(OP_TICK, 8'h00);
        send_event(OP_PULSE, 8'h00);
        send_event(OP_PULSE, 8'h00);
        repeat (4) send_event(OP_TICK, 8'hFF);
        send_event(OP_BYTE, 8'h00);
        send_event(OP_BYTE, 8'h0A);
        send_event(OP_BYTE, 8'h01);
        send_event(OP_BYTE, START_BYTE);
        send_event(OP_BYTE, START_BYTE);
        send_event(OP_BYTE, 8'h00);
        send_event(OP_BYTE, 8'h00);
    endtask

    // A window of zero ticks closes on every tick
    task automatic test_zero_window();
        apply_settings(10'd0, 10'd1, 10'd1023, 10'd256, 10'd512);
        send_event(OP_BYTE, START_BYTE);
        send_event(OP_BYTE, 8'd100);
        send_event(OP_BYTE, 8'd1);
        run_mix(60);
    endtask

    // Zero divisor saturates the raw speed; alpha above one and the largest gain
    task automatic test_zero_divisor();
        apply_settings(10'd3, 10'd0, 10'd1, 10'd511, 10'd1023);
        run_mix(60);
    endtask

    // Pulse count stops at 255 and the raw speed saturates
    task automatic test_pulse_saturation();
        apply_settings(10'd1, 10'd1, 10'd1023, 10'd256, 10'd256);
        sender_gaps  = 1'b0;
        ready_stalls = 1'b0;
        repeat (260) send_event(OP_PULSE, BYTE_W'($urandom));
        send_event(OP_TICK, BYTE_W'($urandom));
        sender_gaps  = 1'b1;
        ready_stalls = 1'b1;
        run_mix(20);
    endtask

    // Zero alpha and zero gain, then a long window with mid-range weights
    task automatic test_filter_extremes();
        apply_settings(10'd1, 10'd255, 10'd1, 10'd0, 10'd0);
        run_mix(50);
        apply_settings(10'd15, 10'd128, 10'd600, 10'd128, 10'd300);
        run_mix(50);
    endtask

    // Random settings per pass; some passes without gaps or stalls
    task automatic test_random_traffic();
        for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
            apply_settings(pick_value(1, 15, 15), pick_value(1, 255, 255),
                           pick_value(1, 1023, 1023), pick_value(0, 256, 511),
                           pick_value(0, 512, 1023));
            sender_gaps  = (pass % 3 != 1);
            ready_stalls = (pass % 4 != 2);
            run_mix(RANDOM_WORDS / RANDOM_PASSES / 2);
            // Let the block run dry in the middle of a pass
            if (pass == RANDOM_PASSES / 2) drain_results();
            run_mix(RANDOM_WORDS / RANDOM_PASSES / 2);
        end
    endtask

    initial begin
        win_ticks_m = WINDOW_TICKS_RST;
        ppr_m       = PULSES_PER_REV_RST;
        scale_m     = RPM_SCALE_RST;
        alpha_m     = ALPHA_RST;
        gain_m      = GAIN_RST;
        tick_cnt    = '0;
        pulse_cnt   = '0;
        speed_filt  = '0;
        frame_pos   = '0;
        frame_ok    = 1'b0;
        frame_duty  = '0;
        duty_sel    = '0;
        motor_mode  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_behavior();
        test_zero_window();
        test_zero_divisor();
        test_pulse_saturation();
        test_filter_extremes();
        test_random_traffic();

        // Wait out the last words, then let the block sit idle before the verdict
        drain_results();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && status_due.size() == 0) begin
            $display("motor_speed_monitor_and_command test passed");
        end else begin
            $display("motor_speed_monitor_and_command test failed");
        end
        $finish;
    end

endmodule
